// ----- rtl/core/ffbta_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_pkg
// Shared constants, micro-operation codes and control/status types for the
// boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ffbta_pkg;

    localparam int unsigned HEAP_BYTES_DEF = 65536;
    localparam int unsigned GROW_CHUNK     = 4096;
    localparam int unsigned MIN_BLOCK      = 16;
    localparam int unsigned LIST_START     = 8;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef logic [5:0] op_t;

    localparam op_t OP_NOP          = 6'd0;
    localparam op_t OP_LOAD         = 6'd1;
    localparam op_t OP_INIT0        = 6'd2;
    localparam op_t OP_INIT1        = 6'd3;
    localparam op_t OP_INIT2        = 6'd4;
    localparam op_t OP_INIT3        = 6'd5;
    localparam op_t OP_OOM          = 6'd6;
    localparam op_t OP_ZERO         = 6'd7;
    localparam op_t OP_EXT          = 6'd8;
    localparam op_t OP_WRD          = 6'd9;
    localparam op_t OP_WSTEP        = 6'd10;
    localparam op_t OP_GROW0        = 6'd11;
    localparam op_t OP_GROW1        = 6'd12;
    localparam op_t OP_GROW2        = 6'd13;
    localparam op_t OP_RD_BPM8      = 6'd14;
    localparam op_t OP_CAP_Q        = 6'd15;
    localparam op_t OP_RD_QM4       = 6'd16;
    localparam op_t OP_CAP_PSZ      = 6'd17;
    localparam op_t OP_RD_PFOOT     = 6'd18;
    localparam op_t OP_CAP_PA       = 6'd19;
    localparam op_t OP_RD_BPM4      = 6'd20;
    localparam op_t OP_CAP_SZ       = 6'd21;
    localparam op_t OP_RD_NM4       = 6'd22;
    localparam op_t OP_CAP_NA       = 6'd23;
    localparam op_t OP_RD_NFOOT     = 6'd24;
    localparam op_t OP_CAP_NFS      = 6'd25;
    localparam op_t OP_SUM_N        = 6'd26;
    localparam op_t OP_SUM_P        = 6'd27;
    localparam op_t OP_WR_HD_TOT    = 6'd28;
    localparam op_t OP_WR_FT_TOT    = 6'd29;
    localparam op_t OP_WR_FTSZ_TOT  = 6'd30;
    localparam op_t OP_WR_QM4_TOT   = 6'd31;
    localparam op_t OP_SET_BPQ      = 6'd32;
    localparam op_t OP_WR_NFOOT_TOT = 6'd33;
    localparam op_t OP_CAP_BP       = 6'd34;
    localparam op_t OP_WR_HD_SZ     = 6'd35;
    localparam op_t OP_WR_FT_SZ     = 6'd36;
    localparam op_t OP_WR_HD_SZA    = 6'd37;
    localparam op_t OP_WR_FT_SZA    = 6'd38;
    localparam op_t OP_WR_HD_NDA    = 6'd39;
    localparam op_t OP_WR_FT_NDA    = 6'd40;
    localparam op_t OP_WR_NHD       = 6'd41;
    localparam op_t OP_WR_NFT       = 6'd42;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } dp_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       req_zero;
        logic       brk_zero;
        logic       free_ok;
        logic       p_lt_brk;
        logic       d_size_zero;
        logic       d_fit;
        logic       grow_ok;
        logic       pa;
        logic       na;
        logic       split_ok;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/ffbta_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_dp
// Datapath: heap word memory, address and size registers, tag arithmetic and
// the result register, driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
module ffbta_dp #(
    parameter int unsigned HEAP_BYTES = ffbta_pkg::HEAP_BYTES_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ffbta_pkg::dp_ctl_t   ctl,
    output ffbta_pkg::dp_sts_t   sts,
    input  wire  [1:0]           command,
    input  wire  [15:0]          request_bytes,
    input  wire  [15:0]          block_address,
    output logic [15:0]          payload_address,
    output logic [1:0]           status
);
    import ffbta_pkg::*;

    localparam int unsigned AW    = $clog2(HEAP_BYTES);
    localparam int unsigned HBW   = AW + 1;
    localparam int unsigned WORDS = HEAP_BYTES / 4;

    logic [31:0]    heap_mem [WORDS];
    logic [31:0]    mem_q_reg;
    logic           mem_we;
    logic [31:0]    mem_addr;
    logic [31:0]    mem_wdata;
    logic [AW-3:0]  mem_idx;

    logic [HBW-1:0] hbrk_reg, hbrk_next;
    logic [31:0]    bp_reg, bp_next;
    logic [31:0]    q_reg, q_next;
    logic [31:0]    n_reg, n_next;
    logic [31:0]    sz_reg, sz_next;
    logic [31:0]    psz_reg, psz_next;
    logic [31:0]    nsz_reg, nsz_next;
    logic [31:0]    tot_reg, tot_next;
    logic [16:0]    need_reg, need_next;
    logic [16:0]    ext_reg, ext_next;
    logic [32:0]    p_reg, p_next;
    logic           pa_reg, pa_next;
    logic           na_reg, na_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic           req_zero_reg, req_zero_next;
    logic [15:0]    result_reg, result_next;
    logic [1:0]     stat_reg, stat_next;
    logic [15:0]    out_addr_reg;
    logic [1:0]     out_stat_reg;

    logic [31:0]    d_sz;
    logic [31:0]    need32;

    assign d_sz    = {mem_q_reg[31:3], 3'b000};
    assign need32  = {15'd0, need_reg};
    assign mem_idx = mem_addr[AW-1:2];

    // tag memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_idx] <= mem_wdata;
        end
        mem_q_reg <= heap_mem[mem_idx];
    end

    always_comb
    begin
        mem_we        = 1'b0;
        mem_addr      = 32'd0;
        mem_wdata     = 32'd0;
        hbrk_next     = hbrk_reg;
        bp_next       = bp_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        sz_next       = sz_reg;
        psz_next      = psz_reg;
        nsz_next      = nsz_reg;
        tot_next      = tot_reg;
        need_next     = need_reg;
        ext_next      = ext_reg;
        p_next        = p_reg;
        pa_next       = pa_reg;
        na_next       = na_reg;
        cmd_next      = cmd_reg;
        req_zero_next = req_zero_reg;
        result_next   = result_reg;
        stat_next     = stat_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_next      = command;
                req_zero_next = (request_bytes == 16'd0);
                need_next     = (request_bytes <= 16'd8) ? 17'(MIN_BLOCK)
                              : (({1'b0, request_bytes} + 17'd15) & 17'h1FFF8);
                bp_next       = {16'd0, block_address};
                p_next        = 33'(LIST_START);
                result_next   = 16'd0;
                stat_next     = ST_OK;
            end
            OP_INIT0:
            begin
                mem_we    = 1'b1;
                mem_addr  = 32'd0;
                mem_wdata = 32'd0;
                hbrk_next = HBW'(16);
            end
            OP_INIT1:
            begin
                mem_we    = 1'b1;
                mem_addr  = 32'd4;
                mem_wdata = 32'd9;
            end
            OP_INIT2:
            begin
                mem_we    = 1'b1;
                mem_addr  = 32'd8;
                mem_wdata = 32'd9;
            end
            OP_INIT3:
            begin
                mem_we    = 1'b1;
                mem_addr  = 32'd12;
                mem_wdata = 32'd1;
                ext_next  = 17'(GROW_CHUNK);
            end
            OP_OOM:
            begin
                stat_next = ST_OOM;
            end
            OP_ZERO:
            begin
                stat_next = ST_ZERO;
            end
            OP_EXT:
            begin
                ext_next = (need_reg > 17'(GROW_CHUNK)) ? need_reg : 17'(GROW_CHUNK);
            end
            OP_WRD:
            begin
                mem_addr = p_reg[31:0] - 32'd4;
            end
            OP_WSTEP:
            begin
                bp_next = p_reg[31:0];
                if (!sts.d_fit)
                begin
                    p_next = p_reg + {1'b0, d_sz};
                end
            end
            OP_GROW0:
            begin
                mem_we    = 1'b1;
                mem_addr  = 32'(hbrk_reg) - 32'd4;
                mem_wdata = {15'd0, ext_reg};
                bp_next   = 32'(hbrk_reg);
                hbrk_next = hbrk_reg + HBW'(ext_reg);
            end
            OP_GROW1:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + {15'd0, ext_reg} - 32'd8;
                mem_wdata = {15'd0, ext_reg};
            end
            OP_GROW2:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + {15'd0, ext_reg} - 32'd4;
                mem_wdata = 32'd1;
            end
            OP_RD_BPM8:
            begin
                mem_addr = bp_reg - 32'd8;
            end
            OP_CAP_Q:
            begin
                q_next = bp_reg - d_sz;
            end
            OP_RD_QM4:
            begin
                mem_addr = q_reg - 32'd4;
            end
            OP_CAP_PSZ:
            begin
                psz_next = d_sz;
            end
            OP_RD_PFOOT:
            begin
                mem_addr = q_reg + psz_reg - 32'd8;
            end
            OP_CAP_PA:
            begin
                pa_next = mem_q_reg[0];
            end
            OP_RD_BPM4:
            begin
                mem_addr = bp_reg - 32'd4;
            end
            OP_CAP_SZ:
            begin
                sz_next = d_sz;
                n_next  = bp_reg + d_sz;
            end
            OP_RD_NM4:
            begin
                mem_addr = n_reg - 32'd4;
            end
            OP_CAP_NA:
            begin
                na_next  = mem_q_reg[0];
                nsz_next = d_sz;
            end
            OP_RD_NFOOT:
            begin
                mem_addr = n_reg + nsz_reg - 32'd8;
            end
            OP_CAP_NFS:
            begin
                tot_next = sz_reg + psz_reg + d_sz;
            end
            OP_SUM_N:
            begin
                tot_next = sz_reg + nsz_reg;
            end
            OP_SUM_P:
            begin
                tot_next = sz_reg + psz_reg;
            end
            OP_WR_HD_TOT:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg - 32'd4;
                mem_wdata = tot_reg;
            end
            OP_WR_FT_TOT:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + tot_reg - 32'd8;
                mem_wdata = tot_reg;
            end
            OP_WR_FTSZ_TOT:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - 32'd8;
                mem_wdata = tot_reg;
            end
            OP_WR_QM4_TOT:
            begin
                mem_we    = 1'b1;
                mem_addr  = q_reg - 32'd4;
                mem_wdata = tot_reg;
            end
            OP_SET_BPQ:
            begin
                bp_next = q_reg;
            end
            OP_WR_NFOOT_TOT:
            begin
                mem_we    = 1'b1;
                mem_addr  = n_reg + nsz_reg - 32'd8;
                mem_wdata = tot_reg;
            end
            OP_CAP_BP:
            begin
                bp_next = bp_reg - d_sz;
            end
            OP_WR_HD_SZ:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg - 32'd4;
                mem_wdata = sz_reg;
            end
            OP_WR_FT_SZ:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - 32'd8;
                mem_wdata = sz_reg;
            end
            OP_WR_HD_SZA:
            begin
                mem_we      = 1'b1;
                mem_addr    = bp_reg - 32'd4;
                mem_wdata   = sz_reg | 32'd1;
                result_next = bp_reg[15:0];
            end
            OP_WR_FT_SZA:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - 32'd8;
                mem_wdata = sz_reg | 32'd1;
            end
            OP_WR_HD_NDA:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg - 32'd4;
                mem_wdata = need32 | 32'd1;
            end
            OP_WR_FT_NDA:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + need32 - 32'd8;
                mem_wdata = need32 | 32'd1;
            end
            OP_WR_NHD:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + need32 - 32'd4;
                mem_wdata = sz_reg - need32;
            end
            OP_WR_NFT:
            begin
                mem_we    = 1'b1;
                mem_addr  = bp_reg + sz_reg - 32'd8;
                mem_wdata = sz_reg - need32;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.req_zero    = req_zero_reg;
        sts.brk_zero    = (hbrk_reg == '0);
        sts.free_ok     = (hbrk_reg != '0) && (bp_reg > 32'(LIST_START))
                          && (bp_reg < 32'(hbrk_reg));
        sts.p_lt_brk    = (p_reg < 33'(hbrk_reg));
        sts.d_size_zero = (d_sz == 32'd0);
        sts.d_fit       = !mem_q_reg[0] && (d_sz >= need32);
        sts.grow_ok     = ((32'(hbrk_reg) + {15'd0, ext_reg}) <= 32'(HEAP_BYTES));
        sts.pa          = pa_reg;
        sts.na          = na_reg;
        sts.split_ok    = ({1'b0, sz_reg} >= ({1'b0, need32} + 33'(MIN_BLOCK)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbrk_reg <= '0;
        end
        else
        begin
            hbrk_reg <= hbrk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg       <= bp_next;
        q_reg        <= q_next;
        n_reg        <= n_next;
        sz_reg       <= sz_next;
        psz_reg      <= psz_next;
        nsz_reg      <= nsz_next;
        tot_reg      <= tot_next;
        need_reg     <= need_next;
        ext_reg      <= ext_next;
        p_reg        <= p_next;
        pa_reg       <= pa_next;
        na_reg       <= na_next;
        cmd_reg      <= cmd_next;
        req_zero_reg <= req_zero_next;
        result_reg   <= result_next;
        stat_reg     <= stat_next;
        if (ctl.out_load)
        begin
            out_addr_reg <= result_reg;
            out_stat_reg <= stat_reg;
        end
    end

    assign payload_address = out_addr_reg;
    assign status          = out_stat_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ffbta_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_ctrl
// Controller: sequences initialize, first-fit walk, heap growth, coalescing
// and block placement as datapath micro-operations; owns the handshakes.
// ----------------------------------------------------------------------------
module ffbta_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    input  ffbta_pkg::dp_sts_t  sts,
    output ffbta_pkg::dp_ctl_t  ctl
);
    import ffbta_pkg::*;

    localparam logic [5:0] S_IDLE      = 6'd0;
    localparam logic [5:0] S_DISPATCH  = 6'd1;
    localparam logic [5:0] S_INIT0     = 6'd2;
    localparam logic [5:0] S_INIT1     = 6'd3;
    localparam logic [5:0] S_INIT2     = 6'd4;
    localparam logic [5:0] S_INIT3     = 6'd5;
    localparam logic [5:0] S_GROW_CHK  = 6'd6;
    localparam logic [5:0] S_GROW1     = 6'd7;
    localparam logic [5:0] S_GROW2     = 6'd8;
    localparam logic [5:0] S_WRD       = 6'd9;
    localparam logic [5:0] S_WSTEP     = 6'd10;
    localparam logic [5:0] S_EXT       = 6'd11;
    localparam logic [5:0] S_M_RD_BPM8 = 6'd12;
    localparam logic [5:0] S_M_CAP_Q   = 6'd13;
    localparam logic [5:0] S_M_RD_QM4  = 6'd14;
    localparam logic [5:0] S_M_CAP_PSZ = 6'd15;
    localparam logic [5:0] S_M_RD_PFT  = 6'd16;
    localparam logic [5:0] S_M_CAP_PA  = 6'd17;
    localparam logic [5:0] S_M_RD_BPM4 = 6'd18;
    localparam logic [5:0] S_M_CAP_SZ  = 6'd19;
    localparam logic [5:0] S_M_RD_NM4  = 6'd20;
    localparam logic [5:0] S_M_CAP_NA  = 6'd21;
    localparam logic [5:0] S_M_BRANCH  = 6'd22;
    localparam logic [5:0] S_A_SUM     = 6'd23;
    localparam logic [5:0] S_A_WHD     = 6'd24;
    localparam logic [5:0] S_A_WFT     = 6'd25;
    localparam logic [5:0] S_B_SUM     = 6'd26;
    localparam logic [5:0] S_B_WFT     = 6'd27;
    localparam logic [5:0] S_B_RD      = 6'd28;
    localparam logic [5:0] S_B_CAPQ    = 6'd29;
    localparam logic [5:0] S_B_WQ      = 6'd30;
    localparam logic [5:0] S_B_SETBP   = 6'd31;
    localparam logic [5:0] S_C_RDNF    = 6'd32;
    localparam logic [5:0] S_C_CAP     = 6'd33;
    localparam logic [5:0] S_C_WQ      = 6'd34;
    localparam logic [5:0] S_C_RDBP    = 6'd35;
    localparam logic [5:0] S_C_CAPSZ   = 6'd36;
    localparam logic [5:0] S_C_RDN     = 6'd37;
    localparam logic [5:0] S_C_CAPN    = 6'd38;
    localparam logic [5:0] S_C_WNF     = 6'd39;
    localparam logic [5:0] S_C_RDBP8   = 6'd40;
    localparam logic [5:0] S_C_CAPBP   = 6'd41;
    localparam logic [5:0] S_M_DONE    = 6'd42;
    localparam logic [5:0] S_F_RD      = 6'd43;
    localparam logic [5:0] S_F_CAP     = 6'd44;
    localparam logic [5:0] S_F_WHD     = 6'd45;
    localparam logic [5:0] S_F_WFT     = 6'd46;
    localparam logic [5:0] S_P_RD      = 6'd47;
    localparam logic [5:0] S_P_CAP     = 6'd48;
    localparam logic [5:0] S_P_WHD     = 6'd49;
    localparam logic [5:0] S_P_WFT     = 6'd50;
    localparam logic [5:0] S_P_CHK     = 6'd51;
    localparam logic [5:0] S_P_WHD2    = 6'd52;
    localparam logic [5:0] S_P_WFT2    = 6'd53;
    localparam logic [5:0] S_P_WNH     = 6'd54;
    localparam logic [5:0] S_P_WNF     = 6'd55;
    localparam logic [5:0] S_FINISH    = 6'd56;

    logic [5:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NOP;
        ctl.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INIT:  state_next = S_INIT0;
                    CMD_ALLOC:
                    begin
                        if (sts.req_zero)
                        begin
                            ctl.op     = OP_ZERO;
                            state_next = S_FINISH;
                        end
                        else if (sts.brk_zero)
                        begin
                            ctl.op     = OP_OOM;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_WRD;
                        end
                    end
                    CMD_FREE:  state_next = sts.free_ok ? S_F_RD : S_FINISH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_INIT0: begin ctl.op = OP_INIT0; state_next = S_INIT1; end
            S_INIT1: begin ctl.op = OP_INIT1; state_next = S_INIT2; end
            S_INIT2: begin ctl.op = OP_INIT2; state_next = S_INIT3; end
            S_INIT3: begin ctl.op = OP_INIT3; state_next = S_GROW_CHK; end
            S_GROW_CHK:
            begin
                if (sts.grow_ok)
                begin
                    ctl.op     = OP_GROW0;
                    state_next = S_GROW1;
                end
                else
                begin
                    ctl.op     = OP_OOM;
                    state_next = S_FINISH;
                end
            end
            S_GROW1: begin ctl.op = OP_GROW1; state_next = S_GROW2; end
            S_GROW2: begin ctl.op = OP_GROW2; state_next = S_M_RD_BPM8; end
            S_WRD:
            begin
                if (sts.p_lt_brk)
                begin
                    ctl.op     = OP_WRD;
                    state_next = S_WSTEP;
                end
                else
                begin
                    state_next = S_EXT;
                end
            end
            S_WSTEP:
            begin
                ctl.op = OP_WSTEP;
                if (sts.d_size_zero)
                begin
                    state_next = S_EXT;
                end
                else if (sts.d_fit)
                begin
                    state_next = S_P_RD;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_EXT:       begin ctl.op = OP_EXT;      state_next = S_GROW_CHK; end
            S_M_RD_BPM8: begin ctl.op = OP_RD_BPM8;  state_next = S_M_CAP_Q; end
            S_M_CAP_Q:   begin ctl.op = OP_CAP_Q;    state_next = S_M_RD_QM4; end
            S_M_RD_QM4:  begin ctl.op = OP_RD_QM4;   state_next = S_M_CAP_PSZ; end
            S_M_CAP_PSZ: begin ctl.op = OP_CAP_PSZ;  state_next = S_M_RD_PFT; end
            S_M_RD_PFT:  begin ctl.op = OP_RD_PFOOT; state_next = S_M_CAP_PA; end
            S_M_CAP_PA:  begin ctl.op = OP_CAP_PA;   state_next = S_M_RD_BPM4; end
            S_M_RD_BPM4: begin ctl.op = OP_RD_BPM4;  state_next = S_M_CAP_SZ; end
            S_M_CAP_SZ:  begin ctl.op = OP_CAP_SZ;   state_next = S_M_RD_NM4; end
            S_M_RD_NM4:  begin ctl.op = OP_RD_NM4;   state_next = S_M_CAP_NA; end
            S_M_CAP_NA:  begin ctl.op = OP_CAP_NA;   state_next = S_M_BRANCH; end
            S_M_BRANCH:
            begin
                if (sts.pa && sts.na)
                begin
                    state_next = S_M_DONE;
                end
                else if (sts.pa)
                begin
                    state_next = S_A_SUM;
                end
                else if (sts.na)
                begin
                    state_next = S_B_SUM;
                end
                else
                begin
                    state_next = S_C_RDNF;
                end
            end
            // merge with the next block
            S_A_SUM:   begin ctl.op = OP_SUM_N;        state_next = S_A_WHD; end
            S_A_WHD:   begin ctl.op = OP_WR_HD_TOT;    state_next = S_A_WFT; end
            S_A_WFT:   begin ctl.op = OP_WR_FT_TOT;    state_next = S_M_DONE; end
            // merge with the previous block
            S_B_SUM:   begin ctl.op = OP_SUM_P;        state_next = S_B_WFT; end
            S_B_WFT:   begin ctl.op = OP_WR_FTSZ_TOT;  state_next = S_B_RD; end
            S_B_RD:    begin ctl.op = OP_RD_BPM8;      state_next = S_B_CAPQ; end
            S_B_CAPQ:  begin ctl.op = OP_CAP_Q;        state_next = S_B_WQ; end
            S_B_WQ:    begin ctl.op = OP_WR_QM4_TOT;   state_next = S_B_SETBP; end
            S_B_SETBP: begin ctl.op = OP_SET_BPQ;      state_next = S_M_DONE; end
            // merge with both neighbors
            S_C_RDNF:  begin ctl.op = OP_RD_NFOOT;     state_next = S_C_CAP; end
            S_C_CAP:   begin ctl.op = OP_CAP_NFS;      state_next = S_C_WQ; end
            S_C_WQ:    begin ctl.op = OP_WR_QM4_TOT;   state_next = S_C_RDBP; end
            S_C_RDBP:  begin ctl.op = OP_RD_BPM4;      state_next = S_C_CAPSZ; end
            S_C_CAPSZ: begin ctl.op = OP_CAP_SZ;       state_next = S_C_RDN; end
            S_C_RDN:   begin ctl.op = OP_RD_NM4;       state_next = S_C_CAPN; end
            S_C_CAPN:  begin ctl.op = OP_CAP_NA;       state_next = S_C_WNF; end
            S_C_WNF:   begin ctl.op = OP_WR_NFOOT_TOT; state_next = S_C_RDBP8; end
            S_C_RDBP8: begin ctl.op = OP_RD_BPM8;      state_next = S_C_CAPBP; end
            S_C_CAPBP: begin ctl.op = OP_CAP_BP;       state_next = S_M_DONE; end
            S_M_DONE:
            begin
                state_next = (sts.cmd == CMD_ALLOC) ? S_P_RD : S_FINISH;
            end
            S_F_RD:    begin ctl.op = OP_RD_BPM4;      state_next = S_F_CAP; end
            S_F_CAP:   begin ctl.op = OP_CAP_SZ;       state_next = S_F_WHD; end
            S_F_WHD:   begin ctl.op = OP_WR_HD_SZ;     state_next = S_F_WFT; end
            S_F_WFT:   begin ctl.op = OP_WR_FT_SZ;     state_next = S_M_RD_BPM8; end
            S_P_RD:    begin ctl.op = OP_RD_BPM4;      state_next = S_P_CAP; end
            S_P_CAP:   begin ctl.op = OP_CAP_SZ;       state_next = S_P_WHD; end
            S_P_WHD:   begin ctl.op = OP_WR_HD_SZA;    state_next = S_P_WFT; end
            S_P_WFT:   begin ctl.op = OP_WR_FT_SZA;    state_next = S_P_CHK; end
            S_P_CHK:
            begin
                state_next = sts.split_ok ? S_P_WHD2 : S_FINISH;
            end
            S_P_WHD2:  begin ctl.op = OP_WR_HD_NDA;    state_next = S_P_WFT2; end
            S_P_WFT2:  begin ctl.op = OP_WR_FT_NDA;    state_next = S_P_WNH; end
            S_P_WNH:   begin ctl.op = OP_WR_NHD;       state_next = S_P_WNF; end
            S_P_WNF:   begin ctl.op = OP_WR_NFT;       state_next = S_FINISH; end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = ctl.out_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_boundary_tag_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit
// First-fit heap allocator with header/footer boundary tags over an on-chip
// word memory of HEAP_BYTES bytes.
// ----------------------------------------------------------------------------
// One command is in flight at a time; the result sits in an output register,
// so the next command is taken while the previous result waits. Every tag
// access goes through the single memory port, and reads are registered.
// Initialize writes the starting tags and then grows the heap. Allocate
// walks the blocks in order until one fits and splits the found block when
// the remainder is large enough. An allocate that grows the heap coalesces
// and splits as the tags allow; one that runs out of memory reports it after
// the walk. Free coalesces the block with its free neighbours unless the
// address is ignored; a zero-size request, an allocate before initialize
// and an unused command leave the heap as it is. A stalled result holds the
// next command in its last cycle until the output register frees. There is
// no clearing pass after reset: the heap memory is written by initialize
// before use.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator_unit #(
    parameter int unsigned HEAP_BYTES = ffbta_pkg::HEAP_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cmd_valid,
    output logic        cmd_ready,
    input  wire  [1:0]  command,
    input  wire  [15:0] request_bytes,
    input  wire  [15:0] block_address,
    output logic        rsp_valid,
    input  wire         rsp_ready,
    output logic [15:0] payload_address,
    output logic [1:0]  status
);
    import ffbta_pkg::*;

    dp_ctl_t ctl;
    dp_sts_t sts;

    ffbta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    ffbta_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .command         (command),
        .request_bytes   (request_bytes),
        .block_address   (block_address),
        .payload_address (payload_address),
        .status          (status)
    );

endmodule
`default_nettype wire

// ----- rtl/core/ffbta_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffbta_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffbta_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cmd_valid,
    input wire        cmd_ready,
    input wire [1:0]  command,
    input wire [15:0] request_bytes,
    input wire [15:0] block_address,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [15:0] payload_address,
    input wire [1:0]  status
);
    import ffbta_pkg::*;

    // stalled response transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_address)
                                    && $stable(status))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK) || (status == ST_OOM) || (status == ST_ZERO))
        else $error("undefined status code");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (payload_address != 16'd0) |-> status == ST_OK)
        else $error("address returned with failure status");

    a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> payload_address[2:0] == 3'd0)
        else $error("payload address not 8-byte aligned");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

endmodule

bind first_fit_boundary_tag_allocator_unit ffbta_checker u_ffbta_checker (.*);
`default_nettype wire
